### src/neighbour_mean_filter_3x3_unit_assert.svh
// Assertion macros shared by the checker of the 3x3 neighbour-mean filter.
// Needs nothing else; it is taken in with an include by the checker file.
`ifndef NEIGHBOUR_MEAN_FILTER_3X3_UNIT_ASSERT_SVH
`define NEIGHBOUR_MEAN_FILTER_3X3_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define NMF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define NMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define NMF_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/nmf_pkg.sv
// Package of the 3x3 neighbour-mean filter: pixel and line store types,
// configuration register codes and geometry constants. Depends on nothing.
package nmf_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 11;
    localparam int CFG_DATA_W = 13;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 13;
    localparam int GEOM_MIN   = 3;
    localparam int GEOM_RESET = 1024;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line_pair;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    function automatic int clamp_geom(input int value, input int upper);
        int res;
        res = value;
        if (value < GEOM_MIN) begin
            res = GEOM_MIN;
        end else if (value > upper) begin
            res = upper;
        end
        return res;
    endfunction

endpackage

### src/nmf_line_store.sv
// Line store of the 3x3 neighbour-mean filter: one synchronous memory whose
// word holds the two previous rows at a column. Depends on nmf_pkg.
module nmf_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output nmf_pkg::t_line_pair      o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  nmf_pkg::t_line_pair      i_wr_data
);
    import nmf_pkg::*;

    t_line_pair r_mem [DEPTH];
    t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/nmf_window.sv
// 3x3 pixel window and neighbour adder tree of the mean filter.
// Depends on nmf_pkg for the pixel type and sum width.
module nmf_window (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  nmf_pkg::t_pix i_top,
    input  nmf_pkg::t_pix i_mid,
    input  nmf_pkg::t_pix i_pixel,
    output nmf_pkg::t_pix o_mean
);
    import nmf_pkg::*;

    t_pix             r_win [9];
    logic [SUM_W-1:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]     <= r_win[i*3 + 1];
                r_win[i*3 + 1] <= r_win[i*3 + 2];
            end
            r_win[2] <= i_top;
            r_win[5] <= i_mid;
            r_win[8] <= i_pixel;
        end
    end

    // The centre pixel sits at index 4 and is left out of the sum.
    assign sum = ((SUM_W'(r_win[0]) + SUM_W'(r_win[1]))
               + (SUM_W'(r_win[2]) + SUM_W'(r_win[3])))
               + ((SUM_W'(r_win[5]) + SUM_W'(r_win[6]))
               + (SUM_W'(r_win[7]) + SUM_W'(r_win[8])));

    assign o_mean = sum[SUM_W-1:SUM_W-PIX_W];

endmodule

### src/neighbour_mean_filter_3x3_unit.sv
// Top level of the 3x3 neighbour-mean filter: counters, geometry registers,
// pipeline control and output register. Depends on nmf_pkg, nmf_line_store, nmf_window.
//
// Usage. Pixels of a frame enter in raster order on i_pixel, one transfer per
// cycle at most (i_valid / o_ready). For every interior pixel one result leaves
// on o_valid / i_ready: the mean of its eight neighbours, its row and column, and
// a flag on the last result of the frame. Border pixels give no result.
// The result for centre (r-1,c-1) is formed from the transfer of pixel (r,c).
// A transfer passes stage 1, stage 2 and the output register before o_valid;
// throughput is one pixel per cycle while the receiver does not stall, set by the
// single read and single write port of the line store memory, which is read at
// transfer and written back when the pixel leaves stage 1.
// Geometry is written through i_cfg_valid / o_cfg_ready with index 0 for the
// width and 1 for the height; o_cfg_ready is always high; width uses data bits 10:0;
// values are clamped to the supported range when written. Write only while idle.
// Reset clears the counters, window and pipeline and sets 1024 by 1024.
// The line store has no clearing pass; the first two rows fill it.
// When the receiver stalls, the result holds and the pipeline fills its empty
// stages before o_ready falls.
module neighbour_mean_filter_3x3_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  nmf_pkg::t_cfg_reg                   i_cfg_index,
    input  logic [nmf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  nmf_pkg::t_pix                       i_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output nmf_pkg::t_pix                       o_mean_value,
    output logic [$clog2(MAX_HEIGHT)-1:0]       o_center_row,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_center_col,
    output logic                                o_last_of_frame
);
    import nmf_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = $clog2(MAX_HEIGHT);
    localparam int WVW       = $clog2(MAX_WIDTH + 1);
    localparam int HVW       = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_RST = clamp_geom(GEOM_RESET, MAX_WIDTH);
    localparam int HEIGHT_RST = clamp_geom(GEOM_RESET, MAX_HEIGHT);

    logic [WVW-1:0] r_width_use;
    logic [HVW-1:0] r_height_use;
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;

    logic           r_s1_valid, r_s1_emit, r_s1_last;
    t_pix           r_s1_pixel;
    logic [CW-1:0]  r_s1_col;
    logic [RW-1:0]  r_s1_row;

    logic           r_s2_emit, r_s2_last;
    logic [CW-1:0]  r_s2_col;
    logic [RW-1:0]  r_s2_row;

    logic           r_o_valid, r_o_last;
    t_pix           r_o_mean;
    logic [CW-1:0]  r_o_col;
    logic [RW-1:0]  r_o_row;

    logic           in_fire, s1_move, s2_move, out_free;
    logic [WVW-1:0] col_ext, col_inc;
    logic [HVW-1:0] row_ext, row_inc;
    logic           col_wrap, emit, last;
    t_line_pair     rd_pair, wr_pair;
    logic           wr_en;
    t_pix           mean;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_use  <= WVW'(WIDTH_RST);
            r_height_use <= HVW'(HEIGHT_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_width_use <= WVW'(clamp_geom(int'(i_cfg_data[IMG_W_BITS-1:0]), MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT: begin
                    r_height_use <= HVW'(clamp_geom(int'(i_cfg_data[IMG_H_BITS-1:0]),
                                                    MAX_HEIGHT));
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_o_valid || i_ready;
    assign s2_move  = !r_s2_emit || out_free;
    assign s1_move  = !r_s1_valid || s2_move;
    assign o_ready  = s1_move;
    assign in_fire  = i_valid && s1_move;

    assign col_ext  = WVW'(r_col);
    assign col_inc  = col_ext + WVW'(1);
    assign row_ext  = HVW'(r_row);
    assign row_inc  = row_ext + HVW'(1);
    assign col_wrap = col_inc >= r_width_use;
    assign emit     = (r_row >= RW'(2)) && (r_col >= CW'(2))
                   && (row_ext < r_height_use) && (col_ext < r_width_use);
    assign last     = (row_inc == r_height_use) && (col_inc == r_width_use);

    always_comb begin
        if (col_wrap) begin
            n_col = '0;
            n_row = (row_inc >= r_height_use) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = (row_ext >= r_height_use) ? '0 : r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_emit  <= emit;
            r_s1_last  <= last;
            r_s1_pixel <= i_pixel;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
        end
    end

    // Accesses to one column are at least three transfers apart, so the
    // write-back of a column always lands before that column is read again.
    assign wr_en         = r_s1_valid && s2_move;
    assign wr_pair.older = rd_pair.newer;
    assign wr_pair.newer = r_s1_pixel;

    nmf_line_store #(
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_rd_en  (in_fire),
        .i_rd_addr(r_col),
        .o_rd_data(rd_pair),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_s1_col),
        .i_wr_data(wr_pair)
    );

    nmf_window u_window (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_shift(wr_en),
        .i_top  (rd_pair.older),
        .i_mid  (rd_pair.newer),
        .i_pixel(r_s1_pixel),
        .o_mean (mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_emit <= 1'b0;
        end else if (s2_move) begin
            r_s2_emit <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_s2_last <= r_s1_last;
            r_s2_col  <= r_s1_col - CW'(1);
            r_s2_row  <= r_s1_row - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_emit) begin
            r_o_mean <= mean;
            r_o_last <= r_s2_last;
            r_o_col  <= r_s2_col;
            r_o_row  <= r_s2_row;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_mean_value    = r_o_mean;
    assign o_center_row    = r_o_row;
    assign o_center_col    = r_o_col;
    assign o_last_of_frame = r_o_last;

endmodule

### src/nmf_checker.sv
// Port checker of the 3x3 neighbour-mean filter and its bind to the top level.
// Depends on nmf_pkg and the assertion macros in neighbour_mean_filter_3x3_unit_assert.svh.
`include "neighbour_mean_filter_3x3_unit_assert.svh"

module nmf_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input nmf_pkg::t_pix                  o_mean_value,
    input logic [$clog2(MAX_HEIGHT)-1:0]  o_center_row,
    input logic [$clog2(MAX_WIDTH)-1:0]   o_center_col,
    input logic                           o_last_of_frame
);
    import nmf_pkg::*;

    `NMF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_mean_value) && $stable(o_center_row) && $stable(o_center_col) && $stable(o_last_of_frame), "result changed while stalled")
    `NMF_ASSERT_NEXT_ANY(a_reset_empty, i_clk, !i_rst_n, !o_valid, "result valid after reset")
    `NMF_ASSERT_NOW(a_interior, i_clk, i_rst_n, o_valid, (o_center_row != '0) && (o_center_col != '0), "result for a border pixel")

endmodule

bind neighbour_mean_filter_3x3_unit nmf_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
) u_nmf_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench of the 3x3 neighbour-mean filter, top level testbench.
// Holds a scoreboard class that predicts every filtered pixel, plus driving tasks.
// Depends on nmf_pkg and neighbour_mean_filter_3x3_unit only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nmf_pkg::*;

    typedef struct {
        t_pix        mean;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } t_mean_result;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_EXTREME,
        STYLE_BRIGHT,
        STYLE_DARK
    } t_pixel_style;

    class mean_scoreboard;
        localparam int unsigned LINE_MAX  = 1024;
        localparam int unsigned FRAME_MAX = 4096;

        t_pix           older_row [LINE_MAX];
        t_pix           newer_row [LINE_MAX];
        t_pix           window [3][3];
        int unsigned    col_count;
        int unsigned    row_count;
        int unsigned    width_reg;
        int unsigned    height_reg;
        t_mean_result   expected_means [$];
        int unsigned    errors;

        function new();
            foreach (older_row[i]) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            foreach (window[i, j]) begin
                window[i][j] = '0;
            end
            col_count  = 0;
            row_count  = 0;
            width_reg  = GEOM_RESET;
            height_reg = GEOM_RESET;
            errors     = 0;
        endfunction

        static function int unsigned clamp_dim(input int unsigned value,
                                               input int unsigned upper);
            int unsigned res;
            res = value;
            if (value < GEOM_MIN) begin
                res = GEOM_MIN;
            end else if (value > upper) begin
                res = upper;
            end
            return res;
        endfunction

        function void write_reg(input t_cfg_reg index, input logic [CFG_DATA_W-1:0] data);
            if (index == REG_IMAGE_WIDTH) begin
                width_reg = data[IMG_W_BITS-1:0];
            end else begin
                height_reg = data[IMG_H_BITS-1:0];
            end
        endfunction

        function void note_pixel(input t_pix px);
            int unsigned  w;
            int unsigned  h;
            int unsigned  c;
            int unsigned  r;
            int unsigned  sum;
            t_pix         top;
            t_pix         mid;
            t_mean_result res;
            w   = clamp_dim(width_reg, LINE_MAX);
            h   = clamp_dim(height_reg, FRAME_MAX);
            c   = col_count;
            r   = row_count;
            top = older_row[c];
            mid = newer_row[c];
            older_row[c] = mid;
            newer_row[c] = px;
            for (int i = 0; i < 3; i++) begin
                window[i][0] = window[i][1];
                window[i][1] = window[i][2];
            end
            window[0][2] = top;
            window[1][2] = mid;
            window[2][2] = px;
            if (r >= 2 && c >= 2 && r < h && c < w) begin
                sum = 0;
                foreach (window[i, j]) begin
                    if (!(i == 1 && j == 1)) begin
                        sum += window[i][j];
                    end
                end
                res.mean = t_pix'(sum >> 3);
                res.row  = 12'(r - 1);
                res.col  = 10'(c - 1);
                res.last = (r == h - 1 && c == w - 1);
                expected_means.push_back(res);
            end
            if (c + 1 >= w) begin
                col_count = 0;
                row_count = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_count = c + 1;
                if (r >= h) begin
                    row_count = 0;
                end
            end
        endfunction

        function void check_mean(input t_pix mean, input logic [11:0] row,
                                 input logic [9:0] col, input logic last);
            t_mean_result exp_res;
            if (expected_means.size() == 0) begin
                $error("unexpected result: mean %0d at row %0d col %0d", mean, row, col);
                errors++;
                return;
            end
            exp_res = expected_means.pop_front();
            if (mean !== exp_res.mean) begin
                $error("mean_value: expected %0d, actual %0d", exp_res.mean, mean);
                errors++;
            end
            if (row !== exp_res.row) begin
                $error("center_row: expected %0d, actual %0d", exp_res.row, row);
                errors++;
            end
            if (col !== exp_res.col) begin
                $error("center_col: expected %0d, actual %0d", exp_res.col, col);
                errors++;
            end
            if (last !== exp_res.last) begin
                $error("last_of_frame: expected %0d, actual %0d", exp_res.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int unsigned SMALL_FRAME_PIXELS = 640;
    localparam int unsigned HOLD_ROW_PIXELS    = 120;
    localparam int unsigned LONG_HOLD          = 300;
    localparam int unsigned SETTLE_CYCLES      = 10;
    localparam int unsigned WATCHDOG_LIMIT     = 3000;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    t_cfg_reg                i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_ready;
    t_pix                    i_pixel     = '0;
    logic                    o_valid;
    logic                    i_ready     = 1'b0;
    t_pix                    o_mean_value;
    logic [11:0]             o_center_row;
    logic [9:0]              o_center_col;
    logic                    o_last_of_frame;

    mean_scoreboard  sb = new();
    int unsigned     pixels_sent = 0;
    int unsigned     calm_in     = 0;
    int unsigned     calm_out    = 0;
    int unsigned     idle_cycles = 0;
    bit              hold_pending = 1'b0;

    neighbour_mean_filter_3x3_unit #(
        .MAX_WIDTH  (mean_scoreboard::LINE_MAX),
        .MAX_HEIGHT (mean_scoreboard::FRAME_MAX)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pixel         (i_pixel),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_mean_value    (o_mean_value),
        .o_center_row    (o_center_row),
        .o_center_col    (o_center_col),
        .o_last_of_frame (o_last_of_frame)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned next_gap(ref int unsigned calm);
        int unsigned roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            calm = $urandom_range(20, 60);
        end
        if (roll < 55) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic t_pix pick_pixel(input t_pixel_style style);
        t_pix px;
        case (style)
            STYLE_EXTREME: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            STYLE_BRIGHT:  px = t_pix'($urandom_range(224, 255));
            STYLE_DARK:    px = t_pix'($urandom_range(0, 31));
            default:       px = t_pix'($urandom);
        endcase
        return px;
    endfunction

    task automatic send_pixel(input t_pix px);
        int unsigned gap;
        gap = next_gap(calm_in);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int unsigned count, input t_pixel_style style);
        for (int unsigned k = 0; k < count; k++) begin
            send_pixel(pick_pixel(style));
        end
    endtask

    task automatic set_geometry(input bit do_w, input logic [CFG_DATA_W-1:0] w,
                                input bit do_h, input logic [CFG_DATA_W-1:0] h);
        if (do_w) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_IMAGE_WIDTH;
            i_cfg_data  <= w;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(REG_IMAGE_WIDTH, w);
        end
        if (do_h) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_IMAGE_HEIGHT;
            i_cfg_data  <= h;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(REG_IMAGE_HEIGHT, h);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_mean(o_mean_value, o_center_row, o_center_col, o_last_of_frame);
            end
            if (hold_pending && o_valid) begin
                hold_pending = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                stall_left = next_gap(calm_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int unsigned  wreg;
        int unsigned  hreg;
        int unsigned  roll;
        int unsigned  frame_pixels;
        bit           do_w;
        bit           do_h;
        t_pixel_style style;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest frames, geometry clamped up from below, sums at both extremes.
        set_geometry(1'b1, 13'd0, 1'b1, 13'd2);
        for (int k = 0; k < 9; k++) begin
            send_pixel((k == 4) ? 8'h00 : 8'hFF);
        end
        for (int k = 0; k < 9; k++) begin
            send_pixel((k == 4) ? 8'hFF : 8'h00);
        end
        wait_idle();

        // Geometry shrunk mid-frame, so that each counter lies beyond its new bound.
        set_geometry(1'b1, 13'd9, 1'b1, 13'd20);
        send_pixels(24, STYLE_RANDOM);
        wait_idle();
        set_geometry(1'b1, 13'd4, 1'b0, '0);
        send_pixels(9, STYLE_RANDOM);
        wait_idle();
        set_geometry(1'b0, '0, 1'b1, 13'd3);
        send_pixels(12, STYLE_RANDOM);
        wait_idle();

        while (pixels_sent < SMALL_FRAME_PIXELS) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                wreg = $urandom_range(0, 2);
            end else if (roll < 3) begin
                wreg = $urandom_range(13, 40);
            end else begin
                wreg = $urandom_range(3, 12);
            end
            if (wreg >= 13) begin
                hreg = $urandom_range(0, 3);
            end else if ($urandom_range(0, 9) == 0) begin
                hreg = $urandom_range(0, 2);
            end else begin
                hreg = $urandom_range(3, 8);
            end
            do_w = ($urandom_range(0, 5) != 0);
            do_h = ($urandom_range(0, 5) != 0);
            set_geometry(do_w, CFG_DATA_W'(wreg), do_h, CFG_DATA_W'(hreg));
            roll = $urandom_range(0, 9);
            style = (roll < 5) ? STYLE_RANDOM : t_pixel_style'(roll % 4);
            frame_pixels = mean_scoreboard::clamp_dim(sb.width_reg, mean_scoreboard::LINE_MAX)
                         * mean_scoreboard::clamp_dim(sb.height_reg, mean_scoreboard::FRAME_MAX);
            send_pixels($urandom_range(1, 3) * frame_pixels, style);
            wait_idle();
        end

        // Tallest frame, clamped from above; the receiver holds off for a long
        // stretch once results start to flow.
        set_geometry(1'b1, CFG_DATA_W'(HOLD_ROW_PIXELS), 1'b1, 13'd8191);
        hold_pending = 1'b1;
        send_pixels(3 * HOLD_ROW_PIXELS, STYLE_RANDOM);
        wait_idle();

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
